### rtl/mse_pkg.sv
// mse_pkg: shared types and constants of the execute unit
// depends on nothing; imported by mse_front, mse_back and mips_subset_execute_unit
`default_nettype none
package mse_pkg;

  localparam int MEM_BYTES = 1024;
  localparam int MEM_WORDS = MEM_BYTES / 4;
  localparam int MEM_AW    = $clog2(MEM_WORDS);
  localparam logic [31:0] PC_RESET = 32'd104;

  typedef enum logic [3:0] {
    ACT_ADD = 4'd0, ACT_SUB = 4'd1, ACT_AND = 4'd2, ACT_DIV = 4'd3, ACT_MUL = 4'd4,
    ACT_LI  = 4'd5, ACT_LW  = 4'd6, ACT_SW  = 4'd7, ACT_J   = 4'd8
  } action_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_MISALIGNED = 3'd1, ST_RANGE = 3'd2, ST_DIV_ZERO = 3'd3,
    ST_INVALID = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    CLS_ALU, CLS_MUL, CLS_DIV, CLS_MEM, CLS_JUMP, CLS_BAD
  } class_t;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_OPER, S_MUL, S_DIV, S_DIVFIN, S_ADDR, S_LOAD
  } back_state_t;

  typedef struct packed {
    logic [3:0]  action;
    logic [4:0]  dest_index;
    logic [4:0]  src_index;
    logic [4:0]  second_index;
    logic signed [31:0] immediate;
    logic [31:0] jump_target;
  } mse_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        wrote_register;
    logic [4:0]  written_index;
    logic signed [31:0] written_value;
    logic signed [31:0] effective_address;
    logic [31:0] next_pc;
  } mse_out_t;

  typedef struct packed {
    mse_in_t instr;
    class_t  cls;
  } mse_entry_t;

  typedef struct packed {
    logic       pop;
    logic       clearing;
  } mse_ctrl_t;

endpackage
`default_nettype wire

### rtl/mse_ram.sv
// mse_ram: generic single write port ram with registered read
// no dependencies
`default_nettype none
module mse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### rtl/mse_front.sv
// mse_front: accepts instructions, classifies them, two-entry queue to the back end
// depends on mse_pkg
`default_nettype none
module mse_front import mse_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire mse_in_t    instr,
  input  wire mse_ctrl_t  ctrl,
  output logic            nonempty,
  output mse_entry_t      head
);
  mse_entry_t q [2];
  logic       wp, rp;
  logic [1:0] count;
  logic       push;
  class_t     cls;

  always_comb begin
    case (instr.action)
      ACT_ADD, ACT_SUB, ACT_AND, ACT_LI: cls = CLS_ALU;
      ACT_MUL:                           cls = CLS_MUL;
      ACT_DIV:                           cls = CLS_DIV;
      ACT_LW, ACT_SW:                    cls = CLS_MEM;
      ACT_J:                             cls = CLS_JUMP;
      default:                           cls = CLS_BAD;
    endcase
  end

  assign busy     = (count == 2'd2) | ctrl.clearing;
  assign push     = start & ~busy;
  assign nonempty = (count != 2'd0);
  assign head     = q[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= '{instr: instr, cls: cls};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (ctrl.pop) rp <= ~rp;
      count <= count + 2'(push) - 2'(ctrl.pop);
    end
  end
endmodule
`default_nettype wire

### rtl/mse_back.sv
// mse_back: executes queued instructions against register file, hi/lo, data memory, pc
// depends on mse_pkg and mse_ram
`default_nettype none
module mse_back import mse_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       nonempty,
  input  wire mse_entry_t head,
  output mse_ctrl_t       ctrl,
  output logic            done,
  output mse_out_t        result
);
  back_state_t state, state_next;
  mse_entry_t  cur;
  logic [31:0] rfa_rdata, rfb_rdata, dm_rdata;
  logic [31:0] rf_valid;
  logic        a_ok, b_ok;
  logic [31:0] a_cur, b_cur, b_q, prod, addr_q, pc, hi, lo;
  logic [32:0] rem;
  logic [31:0] quo, dvs;
  logic        sa, sq;
  logic [4:0]  dcnt;
  logic [MEM_AW-1:0] ccnt;
  logic [32:0] rem_sh, rem_sub;

  logic        fin, fin_jump, wr_req, rf_we, hilo_we, dm_we_sw;
  logic [4:0]  widx;
  logic [31:0] wval, hi_v, lo_v, pc_next, q_fin, r_fin;
  logic [2:0]  st;
  logic        misal, oor;

  logic              dm_we;
  logic [MEM_AW-1:0] dm_waddr;
  logic [31:0]       dm_wdata;

  mse_ram #(.WIDTH(32), .DEPTH(32)) u_rfa (
    .clk(clk), .we(rf_we), .waddr(widx), .wdata(wval),
    .raddr(head.instr.src_index), .rdata(rfa_rdata)
  );
  mse_ram #(.WIDTH(32), .DEPTH(32)) u_rfb (
    .clk(clk), .we(rf_we), .waddr(widx), .wdata(wval),
    .raddr(head.instr.second_index), .rdata(rfb_rdata)
  );
  mse_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_dmem (
    .clk(clk), .we(dm_we), .waddr(dm_waddr), .wdata(dm_wdata),
    .raddr(addr_q[MEM_AW+1:2]), .rdata(dm_rdata)
  );

  assign a_cur   = a_ok ? rfa_rdata : 32'd0;
  assign b_cur   = b_ok ? rfb_rdata : 32'd0;
  assign misal   = (addr_q[1:0] != 2'd0);
  assign oor     = addr_q[31] | (addr_q[31:2] >= 30'(MEM_WORDS));
  assign rem_sh  = {rem[31:0], quo[31]};
  assign rem_sub = rem_sh - {1'b0, dvs};
  assign q_fin   = sq ? (32'd0 - quo) : quo;
  assign r_fin   = sa ? (32'd0 - rem[31:0]) : rem[31:0];

  assign ctrl.pop      = (state == S_IDLE) & nonempty;
  assign ctrl.clearing = (state == S_CLEAR);

  assign dm_we    = (state == S_CLEAR) | dm_we_sw;
  assign dm_waddr = (state == S_CLEAR) ? ccnt : addr_q[MEM_AW+1:2];
  assign dm_wdata = (state == S_CLEAR) ? {{(30-MEM_AW){1'b0}}, ccnt, 2'b00} : b_q;

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:  if (ccnt == MEM_AW'(MEM_WORDS - 1)) state_next = S_IDLE;
      S_IDLE:   if (nonempty) state_next = S_OPER;
      S_OPER: begin
        case (cur.cls)
          CLS_MUL: state_next = S_MUL;
          CLS_DIV: state_next = (b_cur == 32'd0) ? S_IDLE : S_DIV;
          CLS_MEM: state_next = S_ADDR;
          default: state_next = S_IDLE;
        endcase
      end
      S_DIV:    if (dcnt == 5'd31) state_next = S_DIVFIN;
      S_ADDR: begin
        if (!misal && !oor && cur.instr.action == ACT_LW) state_next = S_LOAD;
        else state_next = S_IDLE;
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    fin = 1'b0; fin_jump = 1'b0; wr_req = 1'b0; widx = cur.instr.dest_index;
    wval = 32'd0; hilo_we = 1'b0; hi_v = 32'd0; lo_v = 32'd0; st = ST_OK;
    dm_we_sw = 1'b0;
    case (state)
      S_OPER: begin
        case (cur.cls)
          CLS_ALU: begin
            fin = 1'b1; wr_req = 1'b1;
            case (cur.instr.action)
              ACT_ADD: wval = a_cur + b_cur;
              ACT_SUB: wval = a_cur - b_cur;
              ACT_AND: wval = a_cur & b_cur;
              default: begin
                wval = cur.instr.immediate;
                widx = cur.instr.second_index;
              end
            endcase
          end
          CLS_DIV: begin
            if (b_cur == 32'd0) begin
              fin = 1'b1; st = ST_DIV_ZERO;
            end
          end
          CLS_JUMP: begin
            fin = 1'b1; fin_jump = 1'b1;
          end
          CLS_BAD: begin
            fin = 1'b1; st = ST_INVALID;
          end
          default: ;
        endcase
      end
      S_MUL: begin
        fin = 1'b1; wr_req = 1'b1; wval = prod; hilo_we = 1'b1; lo_v = prod;
      end
      S_DIVFIN: begin
        fin = 1'b1; wr_req = 1'b1; wval = q_fin; hilo_we = 1'b1; lo_v = q_fin; hi_v = r_fin;
      end
      S_ADDR: begin
        widx = cur.instr.second_index;
        if (misal) begin
          fin = 1'b1; st = ST_MISALIGNED;
        end else if (oor) begin
          fin = 1'b1; st = ST_RANGE;
        end else if (cur.instr.action == ACT_SW) begin
          fin = 1'b1; dm_we_sw = 1'b1;
        end
      end
      S_LOAD: begin
        fin = 1'b1; wr_req = 1'b1; widx = cur.instr.second_index; wval = dm_rdata;
      end
      default: ;
    endcase
    rf_we   = fin & wr_req & (widx != 5'd0);
    pc_next = fin_jump ? cur.instr.jump_target : pc + 32'd4;
  end

  always_ff @(posedge clk) begin
    if (ctrl.pop) begin
      cur  <= head;
      a_ok <= rf_valid[head.instr.src_index] & (head.instr.src_index != 5'd0);
      b_ok <= rf_valid[head.instr.second_index] & (head.instr.second_index != 5'd0);
    end
    if (state == S_OPER) begin
      b_q    <= b_cur;
      prod   <= a_cur * b_cur;
      addr_q <= a_cur + cur.instr.immediate;
      sa     <= a_cur[31];
      sq     <= a_cur[31] ^ b_cur[31];
      quo    <= a_cur[31] ? (32'd0 - a_cur) : a_cur;
      dvs    <= b_cur[31] ? (32'd0 - b_cur) : b_cur;
      rem    <= 33'd0;
      dcnt   <= 5'd0;
    end
    if (state == S_DIV) begin
      if (!rem_sub[32]) begin
        rem <= rem_sub;
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[30:0], 1'b0};
      end
      dcnt <= dcnt + 5'd1;
    end
    if (fin) begin
      result.status            <= st;
      result.wrote_register    <= rf_we;
      result.written_index     <= rf_we ? widx : 5'd0;
      result.written_value     <= rf_we ? wval : 32'd0;
      result.effective_address <= (cur.cls == CLS_MEM) ? addr_q : 32'd0;
      result.next_pc           <= pc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      ccnt     <= '0;
      rf_valid <= 32'd0;
      hi       <= 32'd0;
      lo       <= 32'd0;
      pc       <= PC_RESET;
      done     <= 1'b0;
    end else begin
      state <= state_next;
      done  <= fin;
      if (state == S_CLEAR) ccnt <= ccnt + 1'b1;
      if (rf_we) rf_valid[widx] <= 1'b1;
      if (fin && hilo_we) begin
        hi <= hi_v;
        lo <= lo_v;
      end
      if (fin) pc <= pc_next;
    end
  end

  a_div_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIVFIN) |-> ($past(state) == S_DIV && $past(dcnt) == 5'd31))
    else $error("divide finished early");
  a_load_path: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOAD) |-> ($past(state) == S_ADDR && cur.instr.action == ACT_LW))
    else $error("load without address check");
  a_fault_no_write: assert property (@(posedge clk) disable iff (rst)
    (fin && st != ST_OK) |-> (!rf_we && !dm_we_sw && !hilo_we))
    else $error("state written on fault");
endmodule
`default_nettype wire

### rtl/mips_subset_execute_unit.sv
// mips_subset_execute_unit: top level, front queue plus execute back end
// depends on mse_pkg, mse_front, mse_back
//
// usage: drive instr and raise start; the transaction is taken at an edge where
// start is high and busy is low. each instruction yields one result transaction:
// done is high for exactly one cycle with result valid in that cycle.
// the receiver cannot stall; results must be taken when done is high.
// add, sub, and, li, j, invalid codes and divide by zero finish in the operand
// state; mul adds a multiply state, sw and address faults finish in the address
// state, lw adds a load state, and div runs the one-bit-per-cycle restoring
// divider (32 steps) and then a finish state. a two-entry queue holds accepted
// instructions while the back end works, so outside the clearing pass busy
// rises only when it is full, and new ones are taken while one executes.
// results come out in order of acceptance.
// reset is synchronous; after it the block runs a clearing pass that loads
// data memory word i with 4*i over all MEM_WORDS words (256 at 1024 bytes);
// busy stays high meanwhile. registers, hi and lo read zero, pc starts at 104.
`default_nettype none
module mips_subset_execute_unit import mse_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  output logic         busy,
  input  wire mse_in_t instr,
  output logic         done,
  output mse_out_t     result
);
  mse_ctrl_t  ctrl;
  logic       nonempty;
  mse_entry_t head;

  mse_front u_front (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .instr(instr),
    .ctrl(ctrl), .nonempty(nonempty), .head(head)
  );

  mse_back u_back (
    .clk(clk), .rst(rst), .nonempty(nonempty), .head(head), .ctrl(ctrl),
    .done(done), .result(result)
  );

  a_zero_reg: assert property (@(posedge clk) disable iff (rst)
    (done && result.wrote_register) |-> (result.written_index != 5'd0))
    else $error("register zero reported written");
  a_status_write: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != ST_OK) |-> !result.wrote_register)
    else $error("write reported with fault");
  a_reset_busy: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> (busy && !done))
    else $error("not busy after reset");
endmodule
`default_nettype wire
